FILE: sv/tls_extension_list_deframer_defines.svh
// ----------------------------------------------------------------------------
// TLS extension list deframer assertion macros
// Concurrent check macros; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef TLS_EXTENSION_LIST_DEFRAMER_DEFINES_SVH
`define TLS_EXTENSION_LIST_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS
`define TED_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tls deframer check failed");
`define TED_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tls deframer check failed");
`else
`define TED_ASSERT_SAME(label, clk, rst, ante, cons)
`define TED_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: sv/tls_ext_pkg.sv
// ----------------------------------------------------------------------------
// TLS extension deframer package
// Result item layout and event kind codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tls_ext_pkg;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  localparam int unsigned ResDepth = 4;
  localparam int unsigned PtrW     = $clog2(ResDepth);
  localparam int unsigned CntW     = $clog2(ResDepth + 1);

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] ext_type;
    logic [15:0] ext_size;
    logic [7:0]  payload_byte;
    logic        ext_final;
    logic        status;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

FILE: sv/tls_extension_list_deframer.sv
// ----------------------------------------------------------------------------
// TLS extension list deframer
// Splits a length-prefixed extension block into header, data and end items.
// ----------------------------------------------------------------------------
//  channel | signals                                   | accepted when
//  --------+-------------------------------------------+------------------------
//  in      | has_byte, data_byte, block_end            | in_valid && in_ready
//  out     | kind, ext_type, ext_size, payload_byte,   | out_valid && out_ready
//          | ext_final, status, last                   |
//
//  One input item per cycle while in_ready is high; each item is decoded in the cycle it is taken.
//  Results enter a four-entry result queue and leave one per cycle while out_ready
//  is high, so an item with two results takes two output transfers.
//  in_ready is high while the queue holds two or fewer results.
//  Synchronous reset returns to the length high byte phase with an empty queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tls_extension_list_deframer_defines.svh"

module tls_extension_list_deframer
  import tls_ext_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        has_byte,
  input  wire logic [7:0]  data_byte,
  input  wire logic        block_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [15:0]      ext_type,
  output logic [15:0]      ext_size,
  output logic [7:0]       payload_byte,
  output logic             ext_final,
  output logic             status,
  output logic             last
);

  typedef enum logic [2:0] {
    PH_LEN_HI  = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_TYPE_HI = 3'd2,
    PH_TYPE_LO = 3'd3,
    PH_SIZE_HI = 3'd4,
    PH_SIZE_LO = 3'd5,
    PH_DATA    = 3'd6
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] block_remaining, block_remaining_next;
  logic [15:0] current_type, current_type_next;
  logic [15:0] ext_remaining, ext_remaining_next;
  logic [15:0] ext_declared, ext_declared_next;
  logic [7:0]  held_high_byte, held_high_byte_next;
  logic        error_seen, error_seen_next;

  res_t            res_mem [ResDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  logic        accept;
  logic        pop;
  logic        byte_ev;
  logic        end_ev;
  logic        end_ok;
  res_t        byte_res;
  res_t        end_res;
  res_t        slot_a;
  res_t        slot_b;
  logic [1:0]  n_push;
  logic [15:0] word;
  logic [15:0] brem_dec;
  logic [15:0] erem_dec;

  assign accept   = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign pop      = out_valid && out_ready;
  assign in_ready = (count <= CntW'(ResDepth - 2));

  assign word     = {held_high_byte, data_byte};
  assign brem_dec = block_remaining - 16'd1;
  assign erem_dec = ext_remaining - 16'd1;

  always_comb begin
    phase_next           = phase;
    block_remaining_next = block_remaining;
    current_type_next    = current_type;
    ext_remaining_next   = ext_remaining;
    ext_declared_next    = ext_declared;
    held_high_byte_next  = held_high_byte;
    error_seen_next      = error_seen;
    byte_ev              = 1'b0;
    byte_res             = '0;
    end_ev               = 1'b0;
    end_ok               = 1'b0;
    end_res              = '0;

    if (accept && has_byte && !error_seen) begin
      unique case (phase)
        PH_LEN_HI: begin
          held_high_byte_next = data_byte;
          phase_next          = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          block_remaining_next = word;
          phase_next           = PH_TYPE_HI;
        end
        PH_TYPE_HI, PH_SIZE_HI: begin
          if (block_remaining == 16'd0) begin
            error_seen_next = 1'b1;
          end else begin
            block_remaining_next = brem_dec;
            held_high_byte_next  = data_byte;
            phase_next           = (phase == PH_TYPE_HI) ? PH_TYPE_LO : PH_SIZE_LO;
          end
        end
        PH_TYPE_LO: begin
          if (block_remaining == 16'd0) begin
            error_seen_next = 1'b1;
          end else begin
            block_remaining_next = brem_dec;
            current_type_next    = word;
            phase_next           = PH_SIZE_HI;
          end
        end
        PH_SIZE_LO: begin
          if (block_remaining == 16'd0) begin
            error_seen_next = 1'b1;
          end else if (word > brem_dec) begin
            block_remaining_next = brem_dec;
            error_seen_next      = 1'b1;
          end else begin
            block_remaining_next  = brem_dec - word;
            ext_declared_next     = word;
            ext_remaining_next    = word;
            byte_ev               = 1'b1;
            byte_res.kind         = KIND_HEADER;
            byte_res.ext_type     = current_type;
            byte_res.ext_size     = word;
            phase_next            = (word == 16'd0) ? PH_TYPE_HI : PH_DATA;
          end
        end
        PH_DATA: begin
          ext_remaining_next    = erem_dec;
          byte_ev               = 1'b1;
          byte_res.kind         = KIND_DATA;
          byte_res.ext_type     = current_type;
          byte_res.ext_size     = ext_declared;
          byte_res.payload_byte = data_byte;
          byte_res.ext_final    = (erem_dec == 16'd0);
          if (erem_dec == 16'd0) begin
            phase_next = PH_TYPE_HI;
          end
        end
        default: begin
          error_seen_next = 1'b1;
        end
      endcase
    end

    if (accept && block_end) begin
      end_ev         = 1'b1;
      end_ok         = !error_seen_next && ((phase_next == PH_LEN_HI) ||
                       ((phase_next == PH_TYPE_HI) && (block_remaining_next == 16'd0)));
      end_res.kind   = KIND_END;
      end_res.status = !end_ok;
      end_res.last   = 1'b1;
      phase_next           = PH_LEN_HI;
      block_remaining_next = '0;
      current_type_next    = '0;
      ext_remaining_next   = '0;
      ext_declared_next    = '0;
      held_high_byte_next  = '0;
      error_seen_next      = 1'b0;
    end

    byte_res.last = !end_ev;
    slot_a = byte_ev ? byte_res : end_res;
    slot_b = end_res;
    n_push = {1'b0, byte_ev} + {1'b0, end_ev};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LEN_HI;
      block_remaining <= '0;
      current_type    <= '0;
      ext_remaining   <= '0;
      ext_declared    <= '0;
      held_high_byte  <= '0;
      error_seen      <= 1'b0;
      wr_ptr          <= '0;
      rd_ptr          <= '0;
      count           <= '0;
    end else begin
      phase           <= phase_next;
      block_remaining <= block_remaining_next;
      current_type    <= current_type_next;
      ext_remaining   <= ext_remaining_next;
      ext_declared    <= ext_declared_next;
      held_high_byte  <= held_high_byte_next;
      error_seen      <= error_seen_next;
      wr_ptr          <= wr_ptr + PtrW'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count + CntW'(n_push) - CntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      res_mem[wr_ptr] <= slot_a;
    end
    if (n_push == 2'd2) begin
      res_mem[wr_ptr + PtrW'(1)] <= slot_b;
    end
  end

  assign kind         = res_mem[rd_ptr].kind;
  assign ext_type     = res_mem[rd_ptr].ext_type;
  assign ext_size     = res_mem[rd_ptr].ext_size;
  assign payload_byte = res_mem[rd_ptr].payload_byte;
  assign ext_final    = res_mem[rd_ptr].ext_final;
  assign status       = res_mem[rd_ptr].status;
  assign last         = res_mem[rd_ptr].last;

  `TED_ASSERT_SAME(a_queue_bound, clk, rst, 1'b1, count <= CntW'(ResDepth))
  `TED_ASSERT_NEXT(a_end_resets, clk, rst, accept && block_end,
                   (phase == PH_LEN_HI) && !error_seen)
  `TED_ASSERT_NEXT(a_idle_item_holds, clk, rst, accept && !has_byte && !block_end,
                   $stable(phase) && $stable(block_remaining))
  `TED_ASSERT_SAME(a_error_silent, clk, rst, error_seen && !rst, !byte_ev)

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TLS extension list deframer testbench
// Sends extension blocks one byte per item: hand-picked blocks first, then
// random well-formed blocks mixed with damaged blocks and stray items. Each
// accepted item runs through a local decoder model. The model's events are
// queued and compared with every result item the block emits. Both sides idle
// at random outside one no-idle run, with one long output stall and two full drains.
// ----------------------------------------------------------------------------

module tb;
  import tls_ext_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 38;
  localparam int RANDOM_ITEMS = 470;

  localparam int END_ON_BYTE = 1;
  localparam int END_MARKER  = 2;

  typedef enum logic [2:0] {
    DF_LEN_HI, DF_LEN_LO, DF_TYPE_HI, DF_TYPE_LO, DF_SIZE_HI, DF_SIZE_LO, DF_DATA
  } deframe_phase_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic        has_byte     = 1'b0;
  logic [7:0]  data_byte    = 8'd0;
  logic        block_end    = 1'b0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [1:0]  kind;
  logic [15:0] ext_type;
  logic [15:0] ext_size;
  logic [7:0]  payload_byte;
  logic        ext_final;
  logic        status;
  logic        last;

  tls_extension_list_deframer dut (.*);

  // decoder model state
  deframe_phase_t dec_phase     = DF_LEN_HI;
  logic [15:0]    dec_blk_left  = '0;
  logic [15:0]    dec_type      = '0;
  logic [15:0]    dec_ext_left  = '0;
  logic [15:0]    dec_ext_size  = '0;
  logic [7:0]     dec_held_hi   = '0;
  logic           dec_error     = 1'b0;

  res_t       pending_events[$];
  logic [7:0] blk[$];
  int         items_sent    = 0;
  int         mismatches    = 0;
  int         src_idle_pct  = IDLE_PCT;
  int         sink_idle_pct = IDLE_PCT;
  logic       hold_req      = 1'b0;
  logic       sink_hold     = 1'b0;

  initial forever #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("tls_extension_list_deframer: mismatch");
    $finish;
  end

  task automatic deframe_reset();
    dec_phase    = DF_LEN_HI;
    dec_blk_left = '0;
    dec_type     = '0;
    dec_ext_left = '0;
    dec_ext_size = '0;
    dec_held_hi  = '0;
    dec_error    = 1'b0;
  endtask

  task automatic deframe_predict(input logic hb, input logic [7:0] b, input logic be);
    res_t        ev[2];
    int          n;
    logic [15:0] sz;
    logic        ok;
    n = 0;
    if (hb && !dec_error) begin
      case (dec_phase)
        DF_LEN_HI: begin
          dec_held_hi = b;
          dec_phase   = DF_LEN_LO;
        end
        DF_LEN_LO: begin
          dec_blk_left = {dec_held_hi, b};
          dec_phase    = DF_TYPE_HI;
        end
        DF_TYPE_HI, DF_SIZE_HI: begin
          if (dec_blk_left == 16'd0) begin
            dec_error = 1'b1;
          end else begin
            dec_blk_left = dec_blk_left - 16'd1;
            dec_held_hi  = b;
            dec_phase    = (dec_phase == DF_TYPE_HI) ? DF_TYPE_LO : DF_SIZE_LO;
          end
        end
        DF_TYPE_LO: begin
          if (dec_blk_left == 16'd0) begin
            dec_error = 1'b1;
          end else begin
            dec_blk_left = dec_blk_left - 16'd1;
            dec_type     = {dec_held_hi, b};
            dec_phase    = DF_SIZE_HI;
          end
        end
        DF_SIZE_LO: begin
          if (dec_blk_left == 16'd0) begin
            dec_error = 1'b1;
          end else begin
            dec_blk_left = dec_blk_left - 16'd1;
            sz = {dec_held_hi, b};
            if (sz > dec_blk_left) begin
              dec_error = 1'b1;
            end else begin
              dec_blk_left = dec_blk_left - sz;
              dec_ext_size = sz;
              dec_ext_left = sz;
              ev[n] = {KIND_HEADER, dec_type, sz, 8'd0, 1'b0, 1'b0, 1'b0};
              n++;
              dec_phase = (sz == 16'd0) ? DF_TYPE_HI : DF_DATA;
            end
          end
        end
        default: begin
          dec_ext_left = dec_ext_left - 16'd1;
          ev[n] = {KIND_DATA, dec_type, dec_ext_size, b, dec_ext_left == 16'd0, 1'b0, 1'b0};
          n++;
          if (dec_ext_left == 16'd0) dec_phase = DF_TYPE_HI;
        end
      endcase
    end
    if (be) begin
      ok = !dec_error && (dec_phase == DF_LEN_HI ||
           (dec_phase == DF_TYPE_HI && dec_blk_left == 16'd0));
      ev[n] = {KIND_END, 16'd0, 16'd0, 8'd0, 1'b0, !ok, 1'b0};
      n++;
      deframe_reset();
    end
    if (n > 0) ev[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_events.push_back(ev[i]);
  endtask

  task automatic send_item(input logic hb, input logic [7:0] b, input logic be);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    has_byte  <= hb;
    data_byte <= b;
    block_end <= be;
    do @(posedge clk); while (!in_ready);
    deframe_predict(hb, b, be);
    if (hb || be) items_sent++;
  endtask

  task automatic send_block(input int end_mode);
    for (int i = 0; i < blk.size(); i++)
      send_item(1'b1, blk[i], end_mode == END_ON_BYTE && i == blk.size() - 1);
    if (end_mode == END_MARKER) send_item(1'b0, 8'($urandom), 1'b1);
  endtask

  task automatic make_block(input int n_ext, input int max_sz);
    int          total;
    logic [15:0] sz;
    logic [15:0] ty;
    blk.delete();
    blk.push_back(8'd0);
    blk.push_back(8'd0);
    total = 0;
    for (int i = 0; i < n_ext; i++) begin
      ty = 16'($urandom);
      sz = 16'($urandom_range(max_sz));
      blk.push_back(ty[15:8]);
      blk.push_back(ty[7:0]);
      blk.push_back(sz[15:8]);
      blk.push_back(sz[7:0]);
      repeat (sz) blk.push_back(8'($urandom));
      total += 4 + sz;
    end
    blk[0] = 8'(total >> 8);
    blk[1] = 8'(total);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(1'b0, 8'hA5, 1'b1);
    blk = '{8'h00, 8'h00};
    send_block(END_ON_BYTE);
    blk = '{8'h00, 8'h05, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'hFF};
    send_block(END_ON_BYTE);
    blk = '{8'h00, 8'h04, 8'h12, 8'h34, 8'h00, 8'h00};
    send_block(END_MARKER);
    blk = '{8'hFF, 8'hFF};
    send_block(END_ON_BYTE);
    blk = '{8'h00, 8'h05, 8'h00, 8'h01, 8'h00, 8'h02, 8'h33};
    send_block(END_ON_BYTE);
    blk = '{8'h00, 8'h00, 8'hAA};
    send_block(END_ON_BYTE);
    send_item(1'b0, 8'h5A, 1'b0);
  endtask

  task automatic test_random(input int target);
    int pick;
    int mode;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      mode = $urandom_range(1) ? END_ON_BYTE : END_MARKER;
      if ($urandom_range(49) == 0) make_block(1, 300);
      else make_block($urandom_range(3), 8);
      if (pick < 60) begin
      end else if (pick < 68) begin
        blk[$urandom_range(1)] ^= 8'(1 << $urandom_range(7));
      end else if (pick < 76) begin
        repeat ($urandom_range(1, blk.size() - 1)) void'(blk.pop_back());
      end else if (pick < 82) begin
        repeat ($urandom_range(1, 4)) blk.push_back(8'($urandom));
      end else if (pick < 88) begin
        if (blk.size() > 2) blk[$urandom_range(2, blk.size() - 1)] = 8'($urandom);
        else blk.push_back(8'($urandom));
      end else begin
        blk.delete();
        repeat ($urandom_range(1, 6))
          send_item(1'($urandom), 8'($urandom), $urandom_range(3) == 0);
      end
      if (blk.size() != 0) send_block(mode);
    end
  endtask

  task automatic test_sink_hold();
    hold_req = 1'b1;
    make_block(4, 6);
    send_block(END_ON_BYTE);
  endtask

  task automatic test_drain_gap();
    wait_drained();
    make_block(2, 5);
    send_block(END_MARKER);
  endtask

  task automatic test_no_idle();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    repeat (4) begin
      make_block(3, 7);
      send_block(END_ON_BYTE);
    end
    src_idle_pct  = IDLE_PCT;
    sink_idle_pct = IDLE_PCT;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(items_sent + RANDOM_ITEMS / 2);
    test_sink_hold();
    test_drain_gap();
    test_no_idle();
    test_random(items_sent + RANDOM_ITEMS / 2);
    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("tls_extension_list_deframer: match");
    end else begin
      $display("tls_extension_list_deframer: mismatch");
    end
    $finish;
  end

  initial begin
    forever begin
      wait (hold_req);
      sink_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      sink_hold <= 1'b0;
      hold_req = 1'b0;
    end
  end

  always @(posedge clk) begin
    out_ready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && out_valid && out_ready) begin
      got = {kind, ext_type, ext_size, payload_byte, ext_final, status, last};
      if (pending_events.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: kind=%0d type=%h size=%h byte=%h fin=%b st=%b last=%b",
                   got.kind, got.ext_type, got.ext_size, got.payload_byte, got.ext_final,
                   got.status, got.last);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        if (got.kind !== want.kind || got.ext_type !== want.ext_type ||
            got.ext_size !== want.ext_size || got.payload_byte !== want.payload_byte ||
            got.ext_final !== want.ext_final || got.status !== want.status ||
            got.last !== want.last) begin
          if (mismatches < 10) begin
            $display("bad result exp: kind=%0d type=%h size=%h byte=%h fin=%b st=%b last=%b",
                     want.kind, want.ext_type, want.ext_size, want.payload_byte,
                     want.ext_final, want.status, want.last);
            $display("           got: kind=%0d type=%h size=%h byte=%h fin=%b st=%b last=%b",
                     got.kind, got.ext_type, got.ext_size, got.payload_byte,
                     got.ext_final, got.status, got.last);
          end
          mismatches++;
        end
      end
    end
  end

endmodule

FILE: tls_extension_list_deframer.f
+incdir+sv
sv/tls_ext_pkg.sv
sv/tls_extension_list_deframer.sv
tb/tb.sv
